/* hw/rtl/spba_pkg.sv */
// ----------------------------------------------------------------------------
// spba_pkg
// Types, codes and helpers for the symmetric pad block address generator.
// ----------------------------------------------------------------------------
package spba_pkg;

  localparam int MAX_BLOCK_SIDE_DEF = 8;
  localparam int DIM_BITS_DEF       = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SIDE_W     = 13;
  localparam int BSIDE_W    = 4;
  localparam int ORIGIN_W   = 13;
  localparam int COORD_W    = 14;
  localparam int ADDR_W     = 32;
  localparam int POS_W      = 6;
  localparam int SRC_W      = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_ROWS = 3'd0,
    CFG_MATRIX_COLS = 3'd1,
    CFG_BLOCK_ROWS  = 3'd2,
    CFG_BLOCK_COLS  = 3'd3,
    CFG_MATRIX_BASE = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_MIR,
    ST_ROW_MUL,
    ST_ROW_ADD,
    ST_COL
  } state_t;

  typedef struct packed {
    logic [SIDE_W-1:0] val;
    logic              clamp;
  } mirror_t;

  // half-sample symmetric reflection, clamped to the nearest edge if too deep
  function automatic mirror_t mirror(input logic signed [COORD_W-1:0] c,
                                     input logic [SIDE_W-1:0] size);
    logic signed [15:0] cw;
    logic signed [15:0] sw;
    logic signed [15:0] r;
    mirror_t            m;
    cw      = $signed({{(16-COORD_W){c[COORD_W-1]}}, c});
    sw      = $signed({{(16-SIDE_W){1'b0}}, size});
    r       = cw;
    m.clamp = 1'b0;
    m.val   = r[SIDE_W-1:0];
    if (cw < 0) begin
      r = -cw - 16'sd1;
      if (r >= sw) begin
        m.clamp = 1'b1;
        m.val   = '0;
      end else begin
        m.val = r[SIDE_W-1:0];
      end
    end else if (cw >= sw) begin
      r = (sw <<< 1) - cw - 16'sd1;
      if (r < 0) begin
        m.clamp = 1'b1;
        m.val   = size - SIDE_W'(1);
      end else begin
        m.val = r[SIDE_W-1:0];
      end
    end
    return m;
  endfunction

endpackage

/* hw/rtl/symmetric_pad_block_address_gen.sv */
// ----------------------------------------------------------------------------
// symmetric_pad_block_address_gen
// Block fetch address generator with half-sample symmetric border padding.
// ----------------------------------------------------------------------------
// A request beat (origin_row, origin_col) starts one block. For every block
// element, in row-major order, one response beat carries the mirrored source
// row and column, the source address base + row*cols + col, the position in
// the block, a clamp flag and last on the final element.
// Each block row begins with setup steps (reflect row, multiply by the row
// stride, add base), then one element per cycle while rsp_stall does not
// hold a valid beat. The first beat passes the row setup steps and then the
// output register. The single row multiplier and the sequencer set the pace.
// req_stall is high while a block is in progress; the next request is taken
// in the cycle after the last beat enters the output register. If rsp_stall
// is high while rsp_valid is set, the output register holds and the
// sequencer waits. Reset (rst, synchronous) returns to idle, drops rsp_valid
// and loads matrix 1x1, block 8x8, base 0. Configuration is to be written
// while idle only; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module symmetric_pad_block_address_gen
  import spba_pkg::*;
#(
  parameter int MAX_BLOCK_SIDE = MAX_BLOCK_SIDE_DEF,
  parameter int DIM_BITS       = DIM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic signed [ORIGIN_W-1:0] origin_row,
  input  logic signed [ORIGIN_W-1:0] origin_col,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [ADDR_W-1:0]          src_address,
  output logic [SRC_W-1:0]           src_row,
  output logic [SRC_W-1:0]           src_col,
  output logic [POS_W-1:0]           block_position,
  output logic                       out_of_range,
  output logic                       last
);

  localparam int OFF_W = (MAX_BLOCK_SIDE > 1) ? $clog2(MAX_BLOCK_SIDE) : 1;
  localparam logic [16:0] SIDE_CAP = 17'(1) << DIM_BITS;
  localparam logic [BSIDE_W-1:0] BSIDE_CAP = BSIDE_W'(MAX_BLOCK_SIDE);

  logic [SIDE_W-1:0]   matrix_rows, matrix_cols;
  logic [BSIDE_W-1:0]  block_rows, block_cols;
  logic [ADDR_W-1:0]   matrix_base;

  logic [SIDE_W-1:0]   rows_eff, cols_eff;
  logic [BSIDE_W-1:0]  brows_eff, bcols_eff;

  state_t state, state_next;

  logic signed [ORIGIN_W-1:0] latched_origin_row, latched_origin_col;
  logic [OFF_W-1:0]    row_offset, col_offset;
  logic [POS_W-1:0]    pos;
  logic [SIDE_W-1:0]   row_src;
  logic                row_clamp;
  logic [2*SIDE_W-1:0] row_prod;
  logic [ADDR_W-1:0]   row_addr;

  logic                accept, emit, col_end, row_end;
  logic signed [COORD_W-1:0] row_coord, col_coord;
  mirror_t             row_m, col_m;

  always_comb begin
    rows_eff = (matrix_rows == '0) ? SIDE_W'(1) :
               ({4'b0, matrix_rows} > SIDE_CAP) ? SIDE_CAP[SIDE_W-1:0] : matrix_rows;
    cols_eff = (matrix_cols == '0) ? SIDE_W'(1) :
               ({4'b0, matrix_cols} > SIDE_CAP) ? SIDE_CAP[SIDE_W-1:0] : matrix_cols;
    brows_eff = (block_rows == '0) ? BSIDE_W'(1) :
                (block_rows > BSIDE_CAP) ? BSIDE_CAP : block_rows;
    bcols_eff = (block_cols == '0) ? BSIDE_W'(1) :
                (block_cols > BSIDE_CAP) ? BSIDE_CAP : block_cols;
  end

  assign row_coord = $signed({latched_origin_row[ORIGIN_W-1], latched_origin_row})
                   + $signed({{(COORD_W-OFF_W){1'b0}}, row_offset});
  assign col_coord = $signed({latched_origin_col[ORIGIN_W-1], latched_origin_col})
                   + $signed({{(COORD_W-OFF_W){1'b0}}, col_offset});
  assign row_m = mirror(row_coord, rows_eff);
  assign col_m = mirror(col_coord, cols_eff);

  assign col_end = (BSIDE_W'(col_offset) == bcols_eff - BSIDE_W'(1));
  assign row_end = (BSIDE_W'(row_offset) == brows_eff - BSIDE_W'(1));

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_ROW_MIR;
      end
      ST_ROW_MIR: state_next = ST_ROW_MUL;
      ST_ROW_MUL: state_next = ST_ROW_ADD;
      ST_ROW_ADD: state_next = ST_COL;
      ST_COL: begin
        if (!rsp_valid || !rsp_stall) begin
          emit = 1'b1;
          if (col_end) state_next = row_end ? ST_IDLE : ST_ROW_MIR;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp_valid   <= 1'b0;
      row_offset  <= '0;
      col_offset  <= '0;
      pos         <= '0;
      matrix_rows <= SIDE_W'(1);
      matrix_cols <= SIDE_W'(1);
      block_rows  <= BSIDE_W'(8);
      block_cols  <= BSIDE_W'(8);
      matrix_base <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_MATRIX_ROWS: matrix_rows <= cfg_data[SIDE_W-1:0];
          CFG_MATRIX_COLS: matrix_cols <= cfg_data[SIDE_W-1:0];
          CFG_BLOCK_ROWS:  block_rows  <= cfg_data[BSIDE_W-1:0];
          CFG_BLOCK_COLS:  block_cols  <= cfg_data[BSIDE_W-1:0];
          CFG_MATRIX_BASE: matrix_base <= cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        row_offset <= '0;
        col_offset <= '0;
        pos        <= '0;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
        pos       <= pos + POS_W'(1);
        if (col_end) begin
          col_offset <= '0;
          row_offset <= row_end ? '0 : row_offset + OFF_W'(1);
        end else begin
          col_offset <= col_offset + OFF_W'(1);
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_origin_row <= '0;
      latched_origin_col <= '0;
    end else if (accept) begin
      latched_origin_row <= origin_row;
      latched_origin_col <= origin_col;
    end
    if (state == ST_ROW_MIR) begin
      row_src   <= row_m.val;
      row_clamp <= row_m.clamp;
    end
    if (state == ST_ROW_MUL) row_prod <= row_src * cols_eff;
    if (state == ST_ROW_ADD) row_addr <= matrix_base + ADDR_W'(row_prod);
    if (emit) begin
      src_address    <= row_addr + ADDR_W'(col_m.val);
      src_row        <= row_src[SRC_W-1:0];
      src_col        <= col_m.val[SRC_W-1:0];
      block_position <= pos;
      out_of_range   <= row_clamp | col_m.clamp;
      last           <= col_end && row_end;
    end
  end

endmodule

/* bench/tb_symmetric_pad_block_address_gen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symmetric_pad_block_address_gen
// Self-checking bench for the symmetric pad block address generator.
// ----------------------------------------------------------------------------
// Origin requests go in on the request channel. A scoreboard works out every
// beat of the block: the mirrored or clamped source row and column, the
// address, the position and the flags. Each response beat is checked against
// the oldest expected one. The run starts with the reset settings and a few
// directed settings: a huge matrix, zero and oversized sides, and shallow and
// deep padding. Random settings follow, origins aimed at the borders. Both
// channels idle in short random bursts, but not in random phases 3, 6 and 8.
// ----------------------------------------------------------------------------
module tb_symmetric_pad_block_address_gen;
  import spba_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LAST  = 3'd7;
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 54;
  localparam int DRAIN_PAUSE      = 8;
  localparam int END_PAUSE        = 16;
  localparam int WATCHDOG_LIMIT   = 1000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SRC_W-1:0]  row;
    logic [SRC_W-1:0]  col;
    logic [POS_W-1:0]  pos;
    logic              clamped;
    logic              last;
  } fetch_beat_t;

  class fetch_scoreboard;
    logic [SIDE_W-1:0]  matrix_rows;
    logic [SIDE_W-1:0]  matrix_cols;
    logic [BSIDE_W-1:0] block_rows;
    logic [BSIDE_W-1:0] block_cols;
    logic [ADDR_W-1:0]  matrix_base;
    fetch_beat_t        expected_beats[$];
    int                 errors;

    function new();
      matrix_rows = 13'd1;
      matrix_cols = 13'd1;
      block_rows  = 4'd8;
      block_cols  = 4'd8;
      matrix_base = '0;
      errors      = 0;
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MATRIX_ROWS: matrix_rows = data[SIDE_W-1:0];
        CFG_MATRIX_COLS: matrix_cols = data[SIDE_W-1:0];
        CFG_BLOCK_ROWS:  block_rows  = data[BSIDE_W-1:0];
        CFG_BLOCK_COLS:  block_cols  = data[BSIDE_W-1:0];
        CFG_MATRIX_BASE: matrix_base = data;
        default: ;
      endcase
    endfunction

    function int eff_side(logic [SIDE_W-1:0] v);
      if (v == 0) return 1;
      if (v > (1 << DIM_BITS_DEF)) return 1 << DIM_BITS_DEF;
      return int'(v);
    endfunction

    function int eff_block(logic [BSIDE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_BLOCK_SIDE_DEF) return MAX_BLOCK_SIDE_DEF;
      return int'(v);
    endfunction

    function int reflect(int c, int size, inout bit clamped);
      int r;
      r = c;
      if (c < 0) begin
        r = -c - 1;
        if (r >= size) begin
          clamped = 1'b1;
          r = 0;
        end
      end else if (c >= size) begin
        r = 2 * size - c - 1;
        if (r < 0) begin
          clamped = 1'b1;
          r = size - 1;
        end
      end
      return r;
    endfunction

    function void add_block(logic signed [ORIGIN_W-1:0] org_row,
                            logic signed [ORIGIN_W-1:0] org_col);
      int          rows, cols, brows, bcols, sr, sc, pos;
      bit          clamped;
      fetch_beat_t b;
      rows  = eff_side(matrix_rows);
      cols  = eff_side(matrix_cols);
      brows = eff_block(block_rows);
      bcols = eff_block(block_cols);
      for (int i = 0; i < brows; i++) begin
        for (int j = 0; j < bcols; j++) begin
          clamped   = 1'b0;
          sr        = reflect(int'(org_row) + i, rows, clamped);
          sc        = reflect(int'(org_col) + j, cols, clamped);
          pos       = i * bcols + j;
          b.addr    = matrix_base + 32'(sr) * 32'(cols) + 32'(sc);
          b.row     = 12'(sr);
          b.col     = 12'(sc);
          b.pos     = 6'(pos);
          b.clamped = clamped;
          b.last    = (pos + 1 == brows * bcols);
          expected_beats.push_back(b);
        end
      end
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_beat(fetch_beat_t got);
      fetch_beat_t exp_b;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none actual %h", $time, got);
        return;
      end
      exp_b = expected_beats.pop_front();
      check_field("src_address", exp_b.addr, got.addr);
      check_field("src_row", 32'(exp_b.row), 32'(got.row));
      check_field("src_col", 32'(exp_b.col), 32'(got.col));
      check_field("block_position", 32'(exp_b.pos), 32'(got.pos));
      check_field("out_of_range", 32'(exp_b.clamped), 32'(got.clamped));
      check_field("last", 32'(exp_b.last), 32'(got.last));
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic signed [ORIGIN_W-1:0] origin_row = '0;
  logic signed [ORIGIN_W-1:0] origin_col = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  logic [ADDR_W-1:0]          src_address;
  logic [SRC_W-1:0]           src_row;
  logic [SRC_W-1:0]           src_col;
  logic [POS_W-1:0]           block_position;
  logic                       out_of_range;
  logic                       last;

  fetch_scoreboard sb;
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              idle_cycles = 0;
  bit              accepted;

  symmetric_pad_block_address_gen uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .origin_row(origin_row), .origin_col(origin_col),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .src_address(src_address), .src_row(src_row), .src_col(src_col),
    .block_position(block_position), .out_of_range(out_of_range), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response-side stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      accepted = 1'b0;
      if (req_valid && !req_stall) begin
        sb.add_block(origin_row, origin_col);
        accepted = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        sb.check_beat('{src_address, src_row, src_col, block_position, out_of_range, last});
        accepted = 1'b1;
      end
      idle_cycles = accepted ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_symmetric_pad_block_address_gen failed");
        $finish;
      end
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.load_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure_matrix(logic [31:0] mrows, logic [31:0] mcols,
                                  logic [31:0] brows, logic [31:0] bcols,
                                  logic [31:0] base);
    write_register(CFG_MATRIX_ROWS, mrows);
    write_register(CFG_MATRIX_COLS, mcols);
    write_register(CFG_BLOCK_ROWS, brows);
    write_register(CFG_BLOCK_COLS, bcols);
    write_register(CFG_MATRIX_BASE, base);
    // writes to unmapped indexes must leave every register alone
    for (int i = CFG_UNMAPPED_FIRST; i <= CFG_UNMAPPED_LAST; i++)
      write_register(CFG_IDX_W'(i), $urandom());
    cfg_write <= 1'b0;
  endtask

  task automatic send_origin(int r, int c);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    origin_row <= ORIGIN_W'(r);
    origin_col <= ORIGIN_W'(c);
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic end_phase();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_side();
    logic [31:0] d;
    d = $urandom();
    case ($urandom_range(0, 9))
      0:       d[SIDE_W-1:0] = '0;
      1:       d[SIDE_W-1:0] = SIDE_W'($urandom_range(4097, 8191));
      2, 3:    d[SIDE_W-1:0] = SIDE_W'($urandom_range(1, 4096));
      default: d[SIDE_W-1:0] = SIDE_W'($urandom_range(1, 16));
    endcase
    return d;
  endfunction

  function automatic logic [31:0] rand_bside();
    logic [31:0] d;
    d = $urandom();
    if ($urandom_range(0, 9) == 0) d[BSIDE_W-1:0] = BSIDE_W'($urandom_range(0, 15));
    else d[BSIDE_W-1:0] = BSIDE_W'($urandom_range(1, 8));
    return d;
  endfunction

  // mostly near the borders, reaching both reflection and clamping
  function automatic int pick_origin(int side);
    int v;
    if ($urandom_range(0, 3) == 0) v = int'($signed(ORIGIN_W'($urandom())));
    else v = int'($urandom_range(0, 3 * side + 20)) - side - 10;
    if (v < -4096) v = -4096;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  initial begin
    sb = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: 1x1 matrix, 8x8 block
    send_origin(0, 0);
    send_origin(-4096, 4095);
    send_origin(4095, -4096);
    send_origin(-1, 1);
    end_phase();

    // largest matrix, address wraps past 2^32
    configure_matrix(32'd4096, 32'd4096, 32'd8, 32'd8, 32'hFFFF_FFC0);
    send_origin(4088, 4088);
    send_origin(-8, -8);
    send_origin(4095, 0);
    send_origin(-4096, -4096);
    send_origin(2000, 2047);
    end_phase();

    // zero sides act as one
    configure_matrix(32'd0, 32'd0, 32'd0, 32'd0, 32'h1234_5678);
    send_origin(0, 0);
    send_origin(5, -5);
    end_phase();

    // oversized sides saturate
    configure_matrix(32'hFFFF_FFFF, 32'd5000, 32'd15, 32'd9, 32'hFFFF_FFFF);
    send_origin(4095, 4095);
    send_origin(-4096, -4096);
    end_phase();

    // small matrix, padding deeper than the matrix
    configure_matrix(32'd3, 32'd2, 32'd8, 32'd1, 32'd100);
    send_origin(-6, -3);
    send_origin(2, 1);
    send_origin(-4096, 4095);
    end_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p % 3 != 2) && (p != RANDOM_PHASES - 1);
      configure_matrix(rand_side(), rand_side(), rand_bside(), rand_bside(), $urandom());
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_origin(pick_origin(sb.eff_side(sb.matrix_rows)),
                    pick_origin(sb.eff_side(sb.matrix_cols)));
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clk);
      if (p != RANDOM_PHASES - 1) repeat (DRAIN_PAUSE) @(negedge clk);
    end

    repeat (END_PAUSE) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_symmetric_pad_block_address_gen passed");
    end else begin
      $display("tb_symmetric_pad_block_address_gen failed");
    end
    $finish;
  end

endmodule

/* symmetric_pad_block_address_gen.f */
hw/rtl/spba_pkg.sv
hw/rtl/symmetric_pad_block_address_gen.sv
bench/tb_symmetric_pad_block_address_gen.sv
